// ===== rtl/imo_pkg.sv =====
// imo_pkg: shared types, constants and helpers for interval_max_overlap.
// Holds the controller state enum, the command and status structs and the
// sort key helper. No dependencies.
package imo_pkg;

    localparam int ValW               = 32;
    localparam int KeyW               = ValW + 1;
    localparam int ResW               = 9;
    localparam int MaxIntervalsDefault = 256;

    typedef logic [KeyW-1:0] t_key;

    typedef enum logic [1:0] {
        S_LOAD,
        S_INS2,
        S_SWEEP,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic ins_close;
        logic pop;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic head_valid;
        logic out_busy;
    } t_stat;

    // signed order mapped to unsigned; close sorts before open at equal value
    function automatic t_key make_key(input logic [ValW-1:0] val, input logic is_close);
        make_key = {~val[ValW-1], val[ValW-2:0], ~is_close};
    endfunction

endpackage

// ===== rtl/imo_sort_chain.sv =====
// imo_sort_chain: insertion sorting chain of event keys, one event per cycle,
// drained from the head one event per cycle. Depends on imo_pkg.
module imo_sort_chain #(
    parameter int Depth = 2 * imo_pkg::MaxIntervalsDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ins,
    input  imo_pkg::t_key i_key,
    input  logic          i_pop,
    output logic          o_head_valid,
    output logic          o_head_close
);
    import imo_pkg::*;

    t_key             r_key [Depth];
    logic [Depth-1:0] r_vld;
    logic [Depth-1:0] gt;

    always_comb begin
        for (int i = 0; i < Depth; i++) begin
            gt[i] = !r_vld[i] || (r_key[i] > i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ins) begin
            for (int i = 0; i < Depth; i++) begin
                if (i == 0) begin
                    if (gt[0]) r_vld[0] <= 1'b1;
                end else if (gt[i-1]) begin
                    r_vld[i] <= r_vld[i-1];
                end else if (gt[i]) begin
                    r_vld[i] <= 1'b1;
                end
            end
        end else if (i_pop) begin
            r_vld <= {1'b0, r_vld[Depth-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ins) begin
            for (int i = 0; i < Depth; i++) begin
                if (i == 0) begin
                    if (gt[0]) r_key[0] <= i_key;
                end else if (gt[i-1]) begin
                    r_key[i] <= r_key[i-1];
                end else if (gt[i]) begin
                    r_key[i] <= i_key;
                end
            end
        end else if (i_pop) begin
            for (int i = 0; i < Depth - 1; i++) begin
                r_key[i] <= r_key[i+1];
            end
        end
    end

    assign o_head_valid = r_vld[0];
    assign o_head_close = !r_key[0][0];

`ifndef SYNTHESIS
    a_vld_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld & (r_vld + Depth'(1))) == '0)
        else $error("sort chain valid bits not contiguous from head");
    a_no_ins_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_ins && i_pop))
        else $error("insert and pop in the same cycle");
`endif

endmodule

// ===== rtl/imo_datapath.sv =====
// imo_datapath: event capture, sorting chain, sweep counters and result register.
// Depends on imo_pkg and imo_sort_chain.
module imo_datapath #(
    parameter int MAX_INTERVALS = imo_pkg::MaxIntervalsDefault
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  imo_pkg::t_cmd             i_cmd,
    output imo_pkg::t_stat            o_stat,
    input  logic [imo_pkg::ValW-1:0]  i_interval_start,
    input  logic [imo_pkg::ValW-1:0]  i_interval_end,
    input  logic                      i_last_interval,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [imo_pkg::ResW-1:0]  o_peak_open
);
    import imo_pkg::*;

    localparam int Depth = 2 * MAX_INTERVALS;
    localparam int CntW  = $clog2(Depth + 1);
    localparam int BestW = $clog2(MAX_INTERVALS + 1);
    localparam int RunW  = BestW + 1;

    logic [ValW-1:0]        r_end;
    logic                   r_last;
    logic                   r_keep;
    logic [CntW-1:0]        r_count;
    logic signed [RunW-1:0] r_run;
    logic [BestW-1:0]       r_best;
    logic                   r_out_valid;
    logic [ResW-1:0]        r_res;

    logic                   keep;
    logic                   ins;
    t_key                   ins_key;
    logic                   head_valid;
    logic                   head_close;
    logic signed [RunW-1:0] run_up;

    assign keep    = ({1'b0, r_count} + (CntW+1)'(2)) <= (CntW+1)'(Depth);
    assign ins     = (i_cmd.capture && keep) || (i_cmd.ins_close && r_keep);
    assign ins_key = i_cmd.capture ? make_key(i_interval_start, 1'b0)
                                   : make_key(r_end, 1'b1);
    assign run_up  = r_run + RunW'(1);

    imo_sort_chain #(.Depth(Depth)) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ins        (ins),
        .i_key        (ins_key),
        .i_pop        (i_cmd.pop),
        .o_head_valid (head_valid),
        .o_head_close (head_close)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_end  <= i_interval_end;
            r_last <= i_last_interval;
            r_keep <= keep;
        end
        if (i_cmd.emit) begin
            r_res <= ResW'(r_best);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_run       <= '0;
            r_best      <= BestW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture && keep) begin
                r_count <= r_count + CntW'(2);
            end
            if (i_cmd.pop) begin
                if (head_close) begin
                    r_run <= r_run - RunW'(1);
                end else begin
                    r_run <= run_up;
                    if (run_up > $signed({1'b0, r_best})) r_best <= run_up[BestW-1:0];
                end
            end
            if (i_cmd.emit) begin
                r_count     <= '0;
                r_run       <= '0;
                r_best      <= BestW'(1);
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.last       = r_last;
    assign o_stat.head_valid = head_valid;
    assign o_stat.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_peak_open       = r_res;

`ifndef SYNTHESIS
    a_best_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_best != '0)
        else $error("best overlap fell to zero");
    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_out_valid && r_count == '0))
        else $error("result beat not presented after emit");
`endif

endmodule

// ===== rtl/imo_ctrl.sv =====
// imo_ctrl: controller state machine sequencing load, insert, sweep and emit.
// Depends on imo_pkg.
module imo_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  imo_pkg::t_stat i_stat,
    output imo_pkg::t_cmd  o_cmd
);
    import imo_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:  if (i_in_valid) n_state = S_INS2;
            S_INS2:  n_state = i_stat.last ? S_SWEEP : S_LOAD;
            S_SWEEP: if (!i_stat.head_valid) n_state = S_EMIT;
            S_EMIT:  if (!i_stat.out_busy) n_state = S_LOAD;
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_LOAD: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_INS2:  o_cmd.ins_close = 1'b1;
            S_SWEEP: o_cmd.pop = i_stat.head_valid;
            S_EMIT:  o_cmd.emit = !i_stat.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/interval_max_overlap.sv =====
// interval_max_overlap: top level, maximum overlap of a set of Q16.16 intervals.
// Depends on imo_pkg, imo_ctrl and imo_datapath.
//
// Input channel: one beat per interval (start, end, last flag) on
// i_in_valid / o_in_ready. Each beat places an open and a close event into a
// sorting chain, one event per cycle: the open event, then the close event.
// Beats beyond MAX_INTERVALS in one set are dropped, but their last flag acts.
// After the flagged beat its close event is inserted, then the chain is drained
// from its head, one event per cycle, while the overlap count is tracked; once
// the chain is seen empty and no earlier result waits, the peak is loaded into
// the result register. No input is taken during the drain.
// Output channel: one beat per set on o_out_valid / i_out_ready, held in a
// result register; the next set is taken while that beat waits. If the
// receiver still stalls when a further result is ready, the block waits.
// Reset (i_rst_n low, synchronous) empties the chain and clears the counts;
// no clearing pass is needed.
module interval_max_overlap #(
    parameter int MAX_INTERVALS = imo_pkg::MaxIntervalsDefault
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [imo_pkg::ValW-1:0] i_interval_start,
    input  logic [imo_pkg::ValW-1:0] i_interval_end,
    input  logic                     i_last_interval,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [imo_pkg::ResW-1:0] o_peak_open
);
    import imo_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    imo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    imo_datapath #(.MAX_INTERVALS(MAX_INTERVALS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_interval_start (i_interval_start),
        .i_interval_end   (i_interval_end),
        .i_last_interval  (i_last_interval),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_peak_open      (o_peak_open)
    );

endmodule
